@@ design/sha1c_pkg.sv @@
// sha1c_pkg: shared types and constants of the SHA-1 compression engine.
// Payload structs, queue entry, initial chaining value and round constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sha1c_pkg;

  localparam int WORD_W          = 32;
  localparam int WORDS_PER_BLOCK = 16;
  localparam int ROUNDS          = 80;
  localparam int DIGEST_WORDS    = 5;
  localparam int QUEUE_DEPTH     = 4;

  // input request as it arrives on the port
  typedef struct packed {
    logic [WORD_W-1:0] message_word;
    logic              start_message;
    logic              emit_digest;
  } in_item_t;

  // one digest word on the result channel
  typedef struct packed {
    logic [WORD_W-1:0] digest_word;
    logic [2:0]        digest_index;
    logic              last_word;
  } out_item_t;

  // classified word travelling from front to back
  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              reload;  // first word of a block with start flag
    logic              last;    // sixteenth word of a block
    logic              emit;    // last word with emit flag
  } q_entry_t;

  localparam logic [WORD_W-1:0] INIT_CHAIN [DIGEST_WORDS] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam logic [WORD_W-1:0] K0 = 32'h5A827999;
  localparam logic [WORD_W-1:0] K1 = 32'h6ED9EBA1;
  localparam logic [WORD_W-1:0] K2 = 32'h8F1BBCDC;
  localparam logic [WORD_W-1:0] K3 = 32'hCA62C1D6;

endpackage

`default_nettype wire

@@ design/sha1c_front.sv @@
// sha1c_front: accepts message words and tags each with its block role.
// Depends on sha1c_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sha1c_front (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  sha1c_pkg::in_item_t in_data,
  output logic                push_valid,
  input  wire                 push_ready,
  output sha1c_pkg::q_entry_t push_entry
);
  import sha1c_pkg::*;

  logic [3:0] pos_r, pos_nxt;
  logic       accept;

  assign in_stall   = !push_ready;
  assign push_valid = in_valid;
  assign accept     = in_valid && push_ready;

  // classify by position within the block
  always_comb begin
    push_entry.word   = in_data.message_word;
    push_entry.reload = (pos_r == 4'd0) && in_data.start_message;
    push_entry.last   = (pos_r == 4'(WORDS_PER_BLOCK - 1));
    push_entry.emit   = push_entry.last && in_data.emit_digest;
  end

  // word position counter, wraps every block
  always_comb begin
    pos_nxt = accept ? pos_r + 4'd1 : pos_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

endmodule

`default_nettype wire

@@ design/sha1c_queue.sv @@
// sha1c_queue: short FIFO of classified words between front and back.
// Depends on sha1c_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sha1c_queue #(
  parameter int DEPTH = sha1c_pkg::QUEUE_DEPTH
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 push_valid,
  output logic                push_ready,
  input  sha1c_pkg::q_entry_t push_entry,
  output logic                pop_valid,
  input  wire                 pop_take,
  output sha1c_pkg::q_entry_t pop_entry
);
  import sha1c_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  q_entry_t        mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            push, pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_entry  = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_take;

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    count_nxt = count_r + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue fill beyond depth");

  a_push_only : assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> count_r == $past(count_r) + 1'b1)
    else $error("queue fill did not grow on push");

  a_pop_only : assert property (@(posedge clk) disable iff (!rst_n)
    pop && !push |=> count_r == $past(count_r) - 1'b1)
    else $error("queue fill did not shrink on pop");

endmodule

`default_nettype wire

@@ design/sha1c_back.sv @@
// sha1c_back: schedule shift line, round unit, chaining value and digest output.
// Depends on sha1c_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sha1c_back (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  pop_valid,
  output logic                 pop_take,
  input  sha1c_pkg::q_entry_t  pop_entry,
  output logic                 out_valid,
  input  wire                  out_stall,
  output sha1c_pkg::out_item_t out_data
);
  import sha1c_pkg::*;

  typedef enum logic [1:0] {S_LOAD, S_ROUND, S_ADD, S_EMIT} state_t;

  state_t            state_r, state_nxt;
  logic [6:0]        round_r, round_nxt;
  logic [2:0]        idx_r, idx_nxt;
  logic              emit_r, emit_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_r, out_nxt;
  logic [WORD_W-1:0] chain_r [DIGEST_WORDS];
  logic [WORD_W-1:0] chain_nxt [DIGEST_WORDS];
  logic [WORD_W-1:0] sched_r [WORDS_PER_BLOCK];
  logic [WORD_W-1:0] vars_r [DIGEST_WORDS];
  logic [WORD_W-1:0] f, k, t, w_new, w_mix;
  logic              pop;

  assign pop_take  = (state_r == S_LOAD);
  assign pop       = pop_valid && pop_take;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // round function: a, b, c, d, e are vars_r[0..4]
  always_comb begin
    if (round_r < 7'd20) begin
      f = (vars_r[1] & vars_r[2]) | (~vars_r[1] & vars_r[3]);
      k = K0;
    end else if (round_r < 7'd40) begin
      f = vars_r[1] ^ vars_r[2] ^ vars_r[3];
      k = K1;
    end else if (round_r < 7'd60) begin
      f = (vars_r[1] & vars_r[2]) | (vars_r[1] & vars_r[3]) | (vars_r[2] & vars_r[3]);
      k = K2;
    end else begin
      f = vars_r[1] ^ vars_r[2] ^ vars_r[3];
      k = K3;
    end
    t = {vars_r[0][26:0], vars_r[0][31:27]} + f + vars_r[4] + sched_r[0] + k;
    // shift line holds W[t..t+15]; next entry is W[t+16]
    w_mix = sched_r[13] ^ sched_r[8] ^ sched_r[2] ^ sched_r[0];
    w_new = {w_mix[30:0], w_mix[31]};
  end

  // control and chaining value
  always_comb begin
    state_nxt     = state_r;
    round_nxt     = round_r;
    idx_nxt       = idx_r;
    emit_nxt      = emit_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    chain_nxt     = chain_r;
    unique case (state_r)
      S_LOAD: begin
        if (pop && pop_entry.reload) begin
          chain_nxt = INIT_CHAIN;
        end
        if (pop && pop_entry.last) begin
          emit_nxt  = pop_entry.emit;
          round_nxt = '0;
          state_nxt = S_ROUND;
        end
      end
      S_ROUND: begin
        round_nxt = round_r + 7'd1;
        if (round_r == 7'(ROUNDS - 1)) begin
          round_nxt = '0;
          state_nxt = S_ADD;
        end
      end
      S_ADD: begin
        for (int i = 0; i < DIGEST_WORDS; i++) begin
          chain_nxt[i] = chain_r[i] + vars_r[i];
        end
        if (emit_r) begin
          idx_nxt              = '0;
          out_valid_nxt        = 1'b1;
          out_nxt.digest_word  = chain_r[0] + vars_r[0];
          out_nxt.digest_index = '0;
          out_nxt.last_word    = 1'b0;
          state_nxt            = S_EMIT;
        end else begin
          state_nxt = S_LOAD;
        end
      end
      S_EMIT: begin
        if (!out_stall) begin
          if (idx_r == 3'(DIGEST_WORDS - 1)) begin
            out_valid_nxt = 1'b0;
            state_nxt     = S_LOAD;
          end else begin
            idx_nxt              = idx_r + 3'd1;
            out_nxt.digest_word  = chain_r[idx_r + 3'd1];
            out_nxt.digest_index = idx_r + 3'd1;
            out_nxt.last_word    = (idx_r + 3'd1 == 3'(DIGEST_WORDS - 1));
          end
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      round_r     <= '0;
      idx_r       <= '0;
      emit_r      <= 1'b0;
      out_valid_r <= 1'b0;
      chain_r     <= INIT_CHAIN;
    end else begin
      state_r     <= state_nxt;
      round_r     <= round_nxt;
      idx_r       <= idx_nxt;
      emit_r      <= emit_nxt;
      out_valid_r <= out_valid_nxt;
      chain_r     <= chain_nxt;
    end
  end

  // digest payload register
  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  // schedule shift line and working variables
  always_ff @(posedge clk) begin
    if (pop) begin
      for (int i = 0; i < WORDS_PER_BLOCK - 1; i++) begin
        sched_r[i] <= sched_r[i + 1];
      end
      sched_r[WORDS_PER_BLOCK - 1] <= pop_entry.word;
      // a reload only ever comes on a first word, so chain_r is current here
      if (pop_entry.last) begin
        vars_r <= chain_r;
      end
    end else if (state_r == S_ROUND) begin
      for (int i = 0; i < WORDS_PER_BLOCK - 1; i++) begin
        sched_r[i] <= sched_r[i + 1];
      end
      sched_r[WORDS_PER_BLOCK - 1] <= w_new;
      vars_r[4] <= vars_r[3];
      vars_r[3] <= vars_r[2];
      vars_r[2] <= {vars_r[1][1:0], vars_r[1][31:2]};
      vars_r[1] <= vars_r[0];
      vars_r[0] <= t;
    end
  end

  a_out_in_emit : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> state_r == S_EMIT)
    else $error("digest shown outside emit phase");

  a_round_bound : assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ROUND |-> round_r < 7'(ROUNDS))
    else $error("round counter overran");

  a_first_digest : assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ADD && emit_r |=> out_valid_r && out_r.digest_index == 3'd0)
    else $error("digest did not start at word zero");

  a_no_pop_busy : assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_LOAD |-> !pop)
    else $error("word taken while compression busy");

endmodule

`default_nettype wire

@@ design/sha1_block_compression.sv @@
// sha1_block_compression: top level of the SHA-1 compression engine.
// Instantiates sha1c_front, sha1c_queue and sha1c_back; uses sha1c_pkg.
//
//   channel | direction | payload     | handshake
//   in_     | input     | in_item_t   | in_valid / in_stall
//   out_    | output    | out_item_t  | out_valid / out_stall
//
// A block takes its sixteen words from the queue, runs 80 rounds in the
// single round unit (one round a cycle), does the chaining add and, with
// emit, shows the five digest words, each held through any output stall.
// The queue of QDEPTH words takes new words while rounds run.
// Synchronous reset loads the initial chaining value; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module sha1_block_compression #(
  parameter int QDEPTH = sha1c_pkg::QUEUE_DEPTH
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  sha1c_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  wire                  out_stall,
  output sha1c_pkg::out_item_t out_data
);
  import sha1c_pkg::*;

  logic     push_valid, push_ready, pop_valid, pop_take;
  q_entry_t push_entry, pop_entry;

  sha1c_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  sha1c_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_take   (pop_take),
    .pop_entry  (pop_entry)
  );

  sha1c_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_take  (pop_take),
    .pop_entry (pop_entry),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
